@@ rtl/text_console_writer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer.
// Each macro names a clock and an active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("text console writer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("text console writer: next-cycle check failed");

`endif

@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Character codes, mode codes and the cursor command type of the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Character codes that the console treats specially.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Attribute of the blanks that fill the screen after reset.
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // Item modes.
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Cursor command: advance after a printed byte or take a line break.
    typedef struct packed {
        logic upd;
        logic newline;
    } cur_cmd_t;

endpackage

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tcw_cursor.sv @@
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor position and the circular top-row pointer of the screen store.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CW      = $clog2(COLUMNS),
    parameter int RW      = $clog2(ROWS),
    parameter int AW      = $clog2(ROWS * COLUMNS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tcw_pkg::cur_cmd_t cmd,
    output logic [CW-1:0]    cur_col,
    output logic [RW-1:0]    cur_row,
    output logic [RW-1:0]    base_row,
    output logic [AW-1:0]    base_addr,
    output logic             scroll
);
    import tcw_pkg::*;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] base_row_reg, base_row_next;
    logic [AW-1:0] base_addr_reg, base_addr_next;
    logic [CW:0]   col_inc;
    logic          row_adv;

    // Next cursor position; a move past the last row rotates the top-row pointer.
    always_comb begin
        col_inc        = {1'b0, col_reg} + {{CW{1'b0}}, 1'b1};
        col_next       = col_reg;
        row_next       = row_reg;
        base_row_next  = base_row_reg;
        base_addr_next = base_addr_reg;
        row_adv        = 1'b0;
        scroll         = 1'b0;
        if (cmd.upd) begin
            if (cmd.newline || (col_inc == (CW+1)'(COLUMNS))) begin
                col_next = '0;
                row_adv  = 1'b1;
            end else begin
                col_next = col_inc[CW-1:0];
            end
            if (row_adv) begin
                if (row_reg == RW'(ROWS - 1)) begin
                    scroll = 1'b1;
                    if (base_row_reg == RW'(ROWS - 1)) begin
                        base_row_next  = '0;
                        base_addr_next = '0;
                    end else begin
                        base_row_next  = base_row_reg + RW'(1);
                        base_addr_next = base_addr_reg + AW'(COLUMNS);
                    end
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end
        end
    end

    // Cursor and pointer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            base_row_reg  <= '0;
            base_addr_reg <= '0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_row_reg  <= base_row_next;
            base_addr_reg <= base_addr_next;
        end
    end

    assign cur_col   = col_reg;
    assign cur_row   = row_reg;
    assign base_row  = base_row_reg;
    assign base_addr = base_addr_reg;

    // The cursor stays on the screen and the row pointer matches its address.
    `TCW_ASSERT_SAME(a_row_on_screen, aclk, aresetn, 1'b1, 32'(row_reg) < ROWS)
    `TCW_ASSERT_SAME(a_col_on_screen, aclk, aresetn, 1'b1, 32'(col_reg) < COLUMNS)
    `TCW_ASSERT_SAME(a_base_consistent, aclk, aresetn, 1'b1,
        32'(base_addr_reg) == 32'(base_row_reg) * COLUMNS)

endmodule

@@ rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with a cursor and scrolling. The screen lives in
// one RAM organized as a ring of rows; a scroll rotates the top-row pointer
// and blanks the row that comes around as the new bottom row.
// Sequence: an item is accepted in IDLE, ADDR forms the cell address, ACC
//   writes or reads the RAM, and RESP loads the result register once the
//   output is free; a NUL put or an out-of-range read skips ACC; a scrolling
//   put adds a CLEAR sweep of COLUMNS cells over the single RAM write port.
// Throughput: one item at a time; the next item is accepted the cycle after
//   the result is loaded.
// Reset: after aresetn a clearing pass writes ROWS*COLUMNS cells (2000 at the
//   default size), one per cycle; no item is accepted until it ends.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // Input item channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_char_code,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    // Result item channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_char,
    output logic [7:0] m_cell_attr,
    output logic [6:0] m_cursor_column,
    output logic [4:0] m_cursor_line
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ADDR  = 6'b000100,
        ST_ACC   = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    attr_reg;

    logic          mode_reg;
    logic [7:0]    char_reg;
    logic [CW-1:0] col_sel_reg;
    logic [RW-1:0] row_phys_reg;
    logic          in_range_reg;
    logic [AW-1:0] addr_reg;

    logic [7:0]    cell_char_reg, cell_attr_reg;
    logic [6:0]    cursor_column_reg;
    logic [4:0]    cursor_line_reg;

    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row, base_row;
    logic [AW-1:0] base_addr;
    logic          scroll;
    cur_cmd_t      cur_cmd;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          in_accept, load_out, is_nl, cell_ok;
    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    logic [RW:0]   row_sum;
    logic [RW-1:0] row_phys;
    logic          in_range;
    logic [7:0]    wr_char;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign load_out  = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    // Attribute register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            attr_reg <= cfg_data;
        end
    end

    // Physical row of the addressed cell: logical row plus the top-row pointer.
    always_comb begin
        row_sel  = (s_mode == MODE_READ) ? RW'(s_read_row) : cur_row;
        col_sel  = (s_mode == MODE_READ) ? CW'(s_read_col) : cur_col;
        row_sum  = {1'b0, row_sel} + {1'b0, base_row};
        row_phys = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS))
                                              : RW'(row_sum);
        in_range = (32'(s_read_row) < ROWS) && (32'(s_read_col) < COLUMNS);
    end

    // Item fields captured at acceptance, then the cell address.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg     <= s_mode;
            char_reg     <= s_char_code;
            col_sel_reg  <= col_sel;
            row_phys_reg <= row_phys;
            in_range_reg <= in_range;
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= AW'(32'(row_phys_reg) * COLUMNS) + AW'(col_sel_reg);
        end
    end

    // Byte classification for put mode.
    assign is_nl   = (char_reg == CH_LF) || (char_reg == CH_CR);
    assign wr_char = (char_reg == CH_TAB) ? CH_SPACE : char_reg;

    // Sequencer and RAM port control.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_cmd       = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = {attr_reg, wr_char};
        case (state_reg)
            ST_INIT: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = {ATTR_RESET, CH_SPACE};
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (mode_reg == MODE_PUT) begin
                    state_next = (char_reg == CH_NUL) ? ST_RESP : ST_ACC;
                end else begin
                    state_next = in_range_reg ? ST_ACC : ST_RESP;
                end
            end
            ST_ACC: begin
                if (mode_reg == MODE_PUT) begin
                    ram_we          = !is_nl;
                    cur_cmd.upd     = 1'b1;
                    cur_cmd.newline = is_nl;
                    if (scroll) begin
                        // The old top row becomes the bottom row and is blanked.
                        clr_addr_next = base_addr;
                        clr_cnt_next  = '0;
                        state_next    = ST_CLEAR;
                    end else begin
                        state_next = ST_RESP;
                    end
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = {attr_reg, CH_SPACE};
                clr_addr_next = clr_addr_reg + AW'(1);
                clr_cnt_next  = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(COLUMNS - 1)) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result register; cell fields are zero unless an in-range read.
    assign cell_ok = (mode_reg == MODE_READ) && in_range_reg;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            cell_char_reg     <= cell_ok ? ram_rdata[7:0] : 8'h00;
            cell_attr_reg     <= cell_ok ? ram_rdata[15:8] : 8'h00;
            cursor_column_reg <= 7'(cur_col);
            cursor_line_reg   <= 5'(cur_row);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_char     = cell_char_reg;
    assign m_cell_attr     = cell_attr_reg;
    assign m_cursor_column = cursor_column_reg;
    assign m_cursor_line   = cursor_line_reg;

    // Cursor and top-row pointer.
    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CW      (CW),
        .RW      (RW),
        .AW      (AW)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cur_cmd),
        .cur_col   (cur_col),
        .cur_row   (cur_row),
        .base_row  (base_row),
        .base_addr (base_addr),
        .scroll    (scroll)
    );

    // Screen store.
    tcw_ram #(
        .WIDTH  (16),
        .DEPTH  (CELLS),
        .ADDR_W (AW)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // No store write while an item can be taken; the sweep stays in one row;
    // an accepted item goes to address generation; results come from RESP only.
    `TCW_ASSERT_SAME(a_no_write_when_ready, aclk, aresetn, s_ready, !ram_we)
    `TCW_ASSERT_SAME(a_clear_in_row, aclk, aresetn, state_reg == ST_CLEAR,
        32'(clr_cnt_reg) < COLUMNS)
    `TCW_ASSERT_NEXT(a_accept_to_addr, aclk, aresetn, in_accept, state_reg == ST_ADDR)
    `TCW_ASSERT_SAME(a_result_from_resp, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == ST_RESP)

endmodule
